>>> sv/hfu_pkg.sv
// Shared types and opcode constants for the hazard and forwarding unit.
package hfu_pkg;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_HALT    = 6'h3F;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_JR      = 6'h08;

    localparam logic [2:0] WB_NONE    = 3'd0;
    localparam logic [2:0] WB_RD      = 3'd1;
    localparam logic [2:0] WB_RT      = 3'd2;
    localparam logic [2:0] WB_READ_RT = 3'd3;

    localparam int unsigned DATA_W = 32;

    // one input word as it arrives on the ports
    typedef struct packed {
        logic [11:0]       id_ops;
        logic [14:0]       id_regs;
        logic [2:0]        id_wb_kind;
        logic              id_nop;
        logic [11:0]       ex_ops;
        logic [14:0]       ex_regs;
        logic [2:0]        ex_wb_kind;
        logic              ex_nop;
        logic [5:0]        mem_opcode;
        logic [9:0]        mem_dest;
        logic [2:0]        mem_wb_kind;
        logic [DATA_W-1:0] mem_result;
    } in_word_t;

    // register matches and instruction classes after the first stage
    typedef struct packed {
        logic              mem_live;
        logic              mem_ld;
        logic              ex_valid;
        logic              ex_live;
        logic              ex_ld;
        logic              ex_nop;
        logic              ex_reads_rt;
        logic              mem_eq_ex_rs;
        logic              mem_eq_ex_rt;
        logic              mem_eq_id_rs;
        logic              mem_eq_id_rt;
        logic              ex_eq_id_rs;
        logic              ex_eq_id_rt;
        logic              id_reads_rt;
        logic              id_shift;
        logic              id_br_two;
        logic              id_br_one;
        logic              id_clear;
        logic              ex_clear;
        logic              ex_shift;
        logic [DATA_W-1:0] result;
    } class_t;

    // raw flags after the second stage, with the pending clear conditions
    typedef struct packed {
        logic              stall;
        logic              id_fwd_rs;
        logic              id_fwd_rt;
        logic              ex_fwd_rs;
        logic              ex_fwd_rt;
        logic              id_clear;
        logic              ex_clear;
        logic              ex_shift;
        logic [DATA_W-1:0] result;
    } flags_t;

    function automatic logic is_load(input logic [5:0] op);
        return (op == OP_LW) || (op == OP_LH) || (op == OP_LHU) ||
               (op == OP_LB) || (op == OP_LBU);
    endfunction

    function automatic logic is_shift_amt(input logic [5:0] op, input logic [5:0] fn);
        return (op == OP_SPECIAL) && ((fn == FN_SLL) || (fn == FN_SRL) || (fn == FN_SRA));
    endfunction

    function automatic logic has_dest(input logic [2:0] kind);
        return (kind == WB_RD) || (kind == WB_RT);
    endfunction

    function automatic logic reads_rt(input logic [2:0] kind);
        return (kind == WB_RD) || (kind == WB_READ_RT);
    endfunction

    // destination register number, zero when the kind writes nothing
    function automatic logic [4:0] dest_of(input logic [2:0] kind, input logic [4:0] rt,
                                           input logic [4:0] rd);
        logic [4:0] d;
        case (kind)
            WB_RD:   d = rd;
            WB_RT:   d = rt;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

endpackage

>>> sv/hfu_classify.sv
// First stage: destination selection, register matches and opcode classes.
module hfu_classify (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic            load,
    input  hfu_pkg::in_word_t in_word,
    output logic            out_valid,
    output hfu_pkg::class_t out_class
);

    logic            valid_reg;
    logic            valid_next;
    hfu_pkg::class_t class_reg;
    hfu_pkg::class_t class_next;

    logic [5:0] id_op, id_fn, ex_op, ex_fn;
    logic [4:0] id_rs, id_rt, ex_rs, ex_rt, ex_rd, mem_rt, mem_rd;
    logic [4:0] ex_dest, mem_dest;
    logic       ex_valid, mem_valid;

    always_comb begin
        id_op  = in_word.id_ops[11:6];
        id_fn  = in_word.id_ops[5:0];
        id_rs  = in_word.id_regs[14:10];
        id_rt  = in_word.id_regs[9:5];
        ex_op  = in_word.ex_ops[11:6];
        ex_fn  = in_word.ex_ops[5:0];
        ex_rs  = in_word.ex_regs[14:10];
        ex_rt  = in_word.ex_regs[9:5];
        ex_rd  = in_word.ex_regs[4:0];
        mem_rt = in_word.mem_dest[9:5];
        mem_rd = in_word.mem_dest[4:0];

        ex_dest   = hfu_pkg::dest_of(in_word.ex_wb_kind, ex_rt, ex_rd);
        mem_dest  = hfu_pkg::dest_of(in_word.mem_wb_kind, mem_rt, mem_rd);
        ex_valid  = hfu_pkg::has_dest(in_word.ex_wb_kind);
        mem_valid = hfu_pkg::has_dest(in_word.mem_wb_kind);

        class_next.mem_live     = mem_valid && (mem_dest != 5'd0);
        class_next.mem_ld       = hfu_pkg::is_load(in_word.mem_opcode);
        class_next.ex_valid     = ex_valid;
        class_next.ex_live      = ex_valid && (ex_dest != 5'd0);
        class_next.ex_ld        = hfu_pkg::is_load(ex_op);
        class_next.ex_nop       = in_word.ex_nop;
        class_next.ex_reads_rt  = hfu_pkg::reads_rt(in_word.ex_wb_kind);
        class_next.mem_eq_ex_rs = (mem_dest == ex_rs);
        class_next.mem_eq_ex_rt = (mem_dest == ex_rt);
        class_next.mem_eq_id_rs = (mem_dest == id_rs);
        class_next.mem_eq_id_rt = (mem_dest == id_rt);
        class_next.ex_eq_id_rs  = (ex_dest == id_rs);
        class_next.ex_eq_id_rt  = (ex_dest == id_rt);
        class_next.id_reads_rt  = hfu_pkg::reads_rt(in_word.id_wb_kind);
        class_next.id_shift     = hfu_pkg::is_shift_amt(id_op, id_fn);
        class_next.id_br_two    = (id_op == hfu_pkg::OP_BEQ) || (id_op == hfu_pkg::OP_BNE);
        class_next.id_br_one    = (id_op == hfu_pkg::OP_BGTZ) ||
                                  ((id_op == hfu_pkg::OP_SPECIAL) && (id_fn == hfu_pkg::FN_JR));
        class_next.id_clear     = in_word.id_nop || (id_op == hfu_pkg::OP_LUI) ||
                                  (id_op == hfu_pkg::OP_HALT);
        class_next.ex_clear     = (ex_op == hfu_pkg::OP_LUI) || (ex_op == hfu_pkg::OP_HALT);
        class_next.ex_shift     = hfu_pkg::is_shift_amt(ex_op, ex_fn);
        class_next.result       = in_word.mem_result;
    end

    assign valid_next = load ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            class_reg <= class_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_class = class_reg;

endmodule

>>> sv/hfu_resolve.sv
// Second stage: stall and forwarding decisions from the stage-one matches.
module hfu_resolve (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic            load,
    input  hfu_pkg::class_t in_class,
    output logic            out_valid,
    output hfu_pkg::flags_t out_flags
);

    logic            valid_reg;
    logic            valid_next;
    hfu_pkg::flags_t flags_reg;
    hfu_pkg::flags_t flags_next;

    logic mem_stall, ex_hit, mem_ld_hit, load_use;

    always_comb begin
        // plain dependence on the memory stage; shift by amount drops the rs part
        mem_stall = in_class.mem_live &&
                    ((in_class.mem_eq_id_rs && !in_class.id_shift &&
                      !(in_class.ex_valid && in_class.ex_eq_id_rs)) ||
                     (in_class.id_reads_rt && in_class.mem_eq_id_rt &&
                      !(in_class.ex_valid && in_class.ex_eq_id_rt)));

        ex_hit     = 1'b0;
        mem_ld_hit = 1'b0;
        flags_next.id_fwd_rs = 1'b0;
        flags_next.id_fwd_rt = 1'b0;

        if (in_class.id_br_two) begin
            ex_hit     = !in_class.ex_nop && in_class.ex_live &&
                         (in_class.ex_eq_id_rs || in_class.ex_eq_id_rt);
            mem_ld_hit = !ex_hit && in_class.mem_live && in_class.mem_ld &&
                         (in_class.mem_eq_id_rs || in_class.mem_eq_id_rt);
            flags_next.id_fwd_rs = !ex_hit && in_class.mem_live && !in_class.mem_ld &&
                                   in_class.mem_eq_id_rs;
            flags_next.id_fwd_rt = !ex_hit && in_class.mem_live && !in_class.mem_ld &&
                                   in_class.mem_eq_id_rt;
        end else if (in_class.id_br_one) begin
            ex_hit     = !in_class.ex_nop && in_class.ex_live && in_class.ex_eq_id_rs;
            mem_ld_hit = !ex_hit && in_class.mem_live && in_class.mem_ld &&
                         in_class.mem_eq_id_rs;
            flags_next.id_fwd_rs = !ex_hit && in_class.mem_live && !in_class.mem_ld &&
                                   in_class.mem_eq_id_rs;
        end

        load_use = in_class.ex_live && in_class.ex_ld &&
                   (in_class.ex_eq_id_rs || (in_class.id_reads_rt && in_class.ex_eq_id_rt));

        flags_next.stall = ((in_class.id_br_two || in_class.id_br_one) ?
                            (ex_hit || mem_ld_hit) : mem_stall) || load_use;
        flags_next.ex_fwd_rs = in_class.mem_live && in_class.mem_eq_ex_rs;
        flags_next.ex_fwd_rt = in_class.mem_live && in_class.ex_reads_rt &&
                               in_class.mem_eq_ex_rt;
        flags_next.id_clear  = in_class.id_clear;
        flags_next.ex_clear  = in_class.ex_clear;
        flags_next.ex_shift  = in_class.ex_shift;
        flags_next.result    = in_class.result;
    end

    assign valid_next = load ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_flags = flags_reg;

endmodule

>>> sv/mips_hazard_forward_unit.sv
// Top level: three-stage hazard detection and forwarding pipeline.
//
// Usage: the input channel (s_*) carries one word per cycle holding the
// decode, execute and memory stage fields of a five-stage MIPS pipeline.
// The result channel (m_*) returns, for each word, the decode stall flag,
// the four forwarding flags and the value to forward (the memory result).
// Both channels use valid/ready; a word moves when both are high.
// Stages: an accepted word passes the match/classify register, the decision
// register and the output register before its result shows on m_valid.
// Throughput: one word per cycle; each stage advances whenever the stage
// after it is empty or moving, so the block keeps accepting while a result
// waits on the output register as long as an earlier stage has room.
// Stall: with m_ready low the output register holds its word and the stages
// behind it fill up; s_ready drops only when all three stages are full.
// Reset: aresetn low (synchronous) empties every stage; results come back
// in input order with nothing dropped or repeated.
module mips_hazard_forward_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [11:0] s_id_ops,
    input  logic [14:0] s_id_regs,
    input  logic [2:0]  s_id_wb_kind,
    input  logic        s_id_nop,
    input  logic [11:0] s_ex_ops,
    input  logic [14:0] s_ex_regs,
    input  logic [2:0]  s_ex_wb_kind,
    input  logic        s_ex_nop,
    input  logic [5:0]  s_mem_opcode,
    input  logic [9:0]  s_mem_dest,
    input  logic [2:0]  s_mem_wb_kind,
    input  logic [31:0] s_mem_result,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_id_stall,
    output logic        m_id_fwd_rs,
    output logic        m_id_fwd_rt,
    output logic        m_ex_fwd_rs,
    output logic        m_ex_fwd_rt,
    output logic [31:0] m_forward_value
);

    hfu_pkg::in_word_t in_word;
    hfu_pkg::class_t   s1_class;
    hfu_pkg::flags_t   s2_flags;
    logic              s1_valid, s2_valid;
    logic              s1_ready, s2_ready, s3_ready;

    logic        out_valid_reg, out_valid_next;
    logic        stall_reg, stall_next;
    logic        id_fwd_rs_reg, id_fwd_rs_next;
    logic        id_fwd_rt_reg, id_fwd_rt_next;
    logic        ex_fwd_rs_reg, ex_fwd_rs_next;
    logic        ex_fwd_rt_reg, ex_fwd_rt_next;
    logic [31:0] value_reg, value_next;

    assign in_word = '{
        id_ops:      s_id_ops,
        id_regs:     s_id_regs,
        id_wb_kind:  s_id_wb_kind,
        id_nop:      s_id_nop,
        ex_ops:      s_ex_ops,
        ex_regs:     s_ex_regs,
        ex_wb_kind:  s_ex_wb_kind,
        ex_nop:      s_ex_nop,
        mem_opcode:  s_mem_opcode,
        mem_dest:    s_mem_dest,
        mem_wb_kind: s_mem_wb_kind,
        mem_result:  s_mem_result
    };

    // a stage advances when the one after it is empty or moving on
    assign s3_ready = !out_valid_reg || m_ready;
    assign s2_ready = !s2_valid || s3_ready;
    assign s1_ready = !s1_valid || s2_ready;
    assign s_ready  = s1_ready;

    hfu_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .load      (s1_ready),
        .in_word   (in_word),
        .out_valid (s1_valid),
        .out_class (s1_class)
    );

    hfu_resolve u_resolve (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .load      (s2_ready),
        .in_class  (s1_class),
        .out_valid (s2_valid),
        .out_flags (s2_flags)
    );

    // final stage: drop flags for nop/lui/halt and shift-amount operands
    always_comb begin
        out_valid_next = s3_ready ? s2_valid : out_valid_reg;
        stall_next     = s2_flags.stall     && !s2_flags.id_clear;
        id_fwd_rs_next = s2_flags.id_fwd_rs && !s2_flags.id_clear;
        id_fwd_rt_next = s2_flags.id_fwd_rt && !s2_flags.id_clear;
        ex_fwd_rs_next = s2_flags.ex_fwd_rs && !s2_flags.ex_clear && !s2_flags.ex_shift;
        ex_fwd_rt_next = s2_flags.ex_fwd_rt && !s2_flags.ex_clear;
        value_next     = s2_flags.result;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_ready) begin
            stall_reg     <= stall_next;
            id_fwd_rs_reg <= id_fwd_rs_next;
            id_fwd_rt_reg <= id_fwd_rt_next;
            ex_fwd_rs_reg <= ex_fwd_rs_next;
            ex_fwd_rt_reg <= ex_fwd_rt_next;
            value_reg     <= value_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_id_stall      = stall_reg;
    assign m_id_fwd_rs     = id_fwd_rs_reg;
    assign m_id_fwd_rt     = id_fwd_rt_reg;
    assign m_ex_fwd_rs     = ex_fwd_rs_reg;
    assign m_ex_fwd_rt     = ex_fwd_rt_reg;
    assign m_forward_value = value_reg;

    // a full first stage blocked by the second keeps its word
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid && !s2_ready |=> s1_valid && $stable(s1_class))
        else $error("stage one word lost while blocked");

    // a full second stage blocked by the output keeps its word
    a_s2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid && !s3_ready |=> s2_valid && $stable(s2_flags))
        else $error("stage two word lost while blocked");

    // input is refused only when every stage is occupied
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> s1_valid && s2_valid && m_valid && !m_ready)
        else $error("input refused with room in the pipeline");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s2_valid && !s1_valid)
        else $error("pipeline not empty after reset");

endmodule
